@@ rtl/core/peer_registry_least_loaded_router_macros.svh @@
// assertion macros for the peer router
`ifndef PEER_REGISTRY_LEAST_LOADED_ROUTER_MACROS_SVH
`define PEER_REGISTRY_LEAST_LOADED_ROUTER_MACROS_SVH
// implication checked every clock outside reset
`define PRR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define PRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/prr_pkg.sv @@
// shared types and constants of the peer router
`default_nettype none
package prr_pkg;
  localparam int PEER_ENTRIES = 8;
  localparam int IDX_W = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
  localparam int CNT_W = $clog2(PEER_ENTRIES + 1);

  localparam logic [1:0] OP_ANNOUNCE  = 2'd0;
  localparam logic [1:0] OP_HEARTBEAT = 2'd1;
  localparam logic [1:0] OP_SPAWN     = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_REMOTE = 3'd2;
  localparam logic [2:0] ST_LOCAL  = 3'd3;
  localparam logic [2:0] ST_NOPEER = 3'd4;

  localparam int FLAG_GPU    = 0;
  localparam int FLAG_STRICT = 1;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SWEEP   = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] node_name;
    logic [15:0] workers_total;
    logic [15:0] workers_free;
    logic [15:0] gpus_total;
    logic [15:0] gpus_free;
    logic [1:0]  spawn_flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] chosen_name;
    logic [3:0]  online_peers;
    logic [18:0] sum_workers_total;
    logic [18:0] sum_workers_free;
    logic [18:0] sum_gpus_total;
    logic [18:0] sum_gpus_free;
    logic [31:0] local_spawns;
    logic [31:0] remote_spawns;
    logic [31:0] failed_spawns;
    logic [7:0]  dropped_mask;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic clear;    // clear scan accumulators
    logic step;     // process entry at scan index
    logic commit;   // apply item action
    logic sweep;    // apply sweep to entry at scan index
    logic publish;  // load output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // scan index at last entry
    logic is_spawn;
    logic do_sweep;  // tick hit sweep interval
    logic mod_busy;  // tick remainder being rebuilt
  } dp_stat_t;

  function automatic logic [63:0] canon_name(input logic [63:0] n);
    logic [63:0] r;
    logic        live;
    r = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (n[b*8 +: 8] == 8'd0) live = 1'b0;
      if (live) r[b*8 +: 8] = n[b*8 +: 8];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/prr_ctrl.sv @@
// sequencer for the peer router
`default_nettype none
module prr_ctrl import prr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     out_busy,
  input  wire dp_stat_t st,
  output logic          in_ready,
  output dp_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_SWP  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !st.mod_busy;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.clear = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (st.last) state_next = S_ACT;
      end
      S_ACT: begin
        cmd.commit = 1'b1;
        cmd.clear = 1'b1;
        if (!st.is_spawn && st.do_sweep) state_next = S_SWP;
        else state_next = S_SUM;
      end
      S_SWP: begin
        cmd.sweep = 1'b1;
        if (st.last) begin
          cmd.clear = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.step = 1'b1;
        if (st.last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/prr_dp.sv @@
// peer table, scan logic and counters
`default_nettype none
module prr_dp import prr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    in_item,
  input  wire dp_cmd_t     cmd,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [7:0]  cfg_data,
  output dp_stat_t         st,
  output out_item_t        res
);
  logic [63:0] peer_name [PEER_ENTRIES];
  logic [PEER_ENTRIES-1:0] peer_online;
  logic [15:0] peer_wt [PEER_ENTRIES];
  logic [15:0] peer_wf [PEER_ENTRIES];
  logic [15:0] peer_gt [PEER_ENTRIES];
  logic [15:0] peer_gf [PEER_ENTRIES];
  logic [31:0] peer_heard [PEER_ENTRIES];
  logic [31:0] tick_count, local_count, remote_count, failed_count;
  logic [7:0]  timeout_ticks, sweep_interval;
  logic [7:0]  tick_mod;  // tick_count mod sweep_interval
  logic [5:0]  mod_cnt;   // remaining bits of the remainder rebuild

  in_item_t    item;
  logic [63:0] name;
  logic [IDX_W-1:0] idx;
  logic        match_ok, free_ok, best_ok;
  logic [IDX_W-1:0] match_idx, free_idx, best_idx;
  logic [15:0] best_key;
  logic [CNT_W-1:0] n_on;
  logic [18:0] s_wt, s_wf, s_gt, s_gf;
  logic [7:0]  dropped;
  logic [2:0]  status;
  logic [63:0] chosen;

  logic        gpu;
  logic [15:0] key;
  logic [31:0] limit;
  logic [7:0]  mod_inc;
  logic        mod_wrap;
  logic [8:0]  mod_sh;

  assign gpu = item.spawn_flags[FLAG_GPU];
  assign key = gpu ? peer_gf[idx] : peer_wf[idx];
  assign limit = peer_heard[idx] + 32'(timeout_ticks);
  assign mod_inc = tick_mod + 8'd1;
  // next tick lands on a multiple of the interval; the 32-bit wrap lands on zero
  assign mod_wrap = (sweep_interval != 8'd0) &&
                    ((mod_inc >= sweep_interval) || (tick_count == '1));
  // restoring remainder step, tick bits taken msb first
  assign mod_sh = {tick_mod, tick_count[5'(mod_cnt - 6'd1)]};

  assign st.last = (idx == IDX_W'(PEER_ENTRIES - 1));
  assign st.is_spawn = (item.op == OP_SPAWN);
  assign st.do_sweep = mod_wrap;
  assign st.mod_busy = (mod_cnt != 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 8'd30;
      sweep_interval <= 8'd10;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_TIMEOUT) timeout_ticks <= cfg_data;
      else sweep_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_online <= '0;
      tick_count <= '0;
      tick_mod <= '0;
      mod_cnt <= '0;
      local_count <= '0;
      remote_count <= '0;
      failed_count <= '0;
      idx <= '0;
      for (int i = 0; i < PEER_ENTRIES; i++) begin
        peer_name[i] <= '0;
        peer_heard[i] <= '0;
      end
    end else begin
      // new interval: rebuild tick_count mod sweep_interval from zero, tick bits msb first
      if (cfg_we && cfg_idx == CFG_SWEEP) begin
        tick_mod <= '0;
        mod_cnt <= 6'd32;
      end else if (mod_cnt != 6'd0) begin
        tick_mod <= (mod_sh >= {1'b0, sweep_interval}) ?
                    8'(mod_sh - {1'b0, sweep_interval}) : mod_sh[7:0];
        mod_cnt <= mod_cnt - 6'd1;
      end
      if (cmd.load) begin
        item <= in_item;
        name <= canon_name(in_item.node_name);
        dropped <= '0;
      end
      if (cmd.clear) begin
        idx <= '0;
        match_ok <= 1'b0;
        free_ok <= 1'b0;
        best_ok <= 1'b0;
        best_key <= '0;
        n_on <= '0;
        s_wt <= '0;
        s_wf <= '0;
        s_gt <= '0;
        s_gf <= '0;
      end
      if (cmd.step) begin
        if (!st.last) idx <= idx + IDX_W'(1);
        if (peer_online[idx]) begin
          if (!match_ok && peer_name[idx] == name) begin
            match_ok <= 1'b1;
            match_idx <= idx;
          end
          if (!(gpu && peer_gf[idx] == 16'd0) && key > best_key) begin
            best_key <= key;
            best_ok <= 1'b1;
            best_idx <= idx;
          end
          n_on <= n_on + CNT_W'(1);
          s_wt <= s_wt + 19'(peer_wt[idx]);
          s_wf <= s_wf + 19'(peer_wf[idx]);
          s_gt <= s_gt + 19'(peer_gt[idx]);
          s_gf <= s_gf + 19'(peer_gf[idx]);
        end else if (!free_ok) begin
          free_ok <= 1'b1;
          free_idx <= idx;
        end
      end
      if (cmd.sweep) begin
        if (!st.last) idx <= idx + IDX_W'(1);
        if (peer_online[idx] && tick_count > limit) begin
          peer_online[idx] <= 1'b0;
          if (32'(idx) < 32'd8) dropped[3'(idx)] <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (item.op == OP_SPAWN) begin
          if (best_ok) begin
            if (gpu) begin
              if (peer_gf[best_idx] != 16'd0) peer_gf[best_idx] <= peer_gf[best_idx] - 16'd1;
            end else if (peer_wf[best_idx] != 16'd0) begin
              peer_wf[best_idx] <= peer_wf[best_idx] - 16'd1;
            end
            remote_count <= remote_count + 32'd1;
            status <= ST_REMOTE;
            chosen <= peer_name[best_idx];
          end else if (item.spawn_flags[FLAG_STRICT]) begin
            failed_count <= failed_count + 32'd1;
            status <= ST_NOPEER;
            chosen <= '0;
          end else begin
            local_count <= local_count + 32'd1;
            status <= ST_LOCAL;
            chosen <= '0;
          end
        end else begin
          chosen <= '0;
          if (item.op == OP_ANNOUNCE && !(match_ok || free_ok)) status <= ST_FULL;
          else status <= ST_OK;
          if (item.op == OP_ANNOUNCE) begin
            if (match_ok || free_ok) begin
              peer_name[match_ok ? match_idx : free_idx] <= name;
              peer_wt[match_ok ? match_idx : free_idx] <= item.workers_total;
              peer_wf[match_ok ? match_idx : free_idx] <= item.workers_free;
              peer_gt[match_ok ? match_idx : free_idx] <= item.gpus_total;
              peer_gf[match_ok ? match_idx : free_idx] <= item.gpus_free;
              peer_heard[match_ok ? match_idx : free_idx] <= tick_count;
              peer_online[match_ok ? match_idx : free_idx] <= 1'b1;
            end
          end else if (item.op == OP_HEARTBEAT && match_ok) begin
            peer_heard[match_idx] <= tick_count;
          end
          tick_count <= tick_count + 32'd1;
          tick_mod <= mod_wrap ? 8'd0 : mod_inc;
        end
      end
    end
  end

  always_comb begin
    res.status = status;
    res.chosen_name = chosen;
    res.online_peers = 4'(n_on);
    res.sum_workers_total = s_wt;
    res.sum_workers_free = s_wf;
    res.sum_gpus_total = s_gt;
    res.sum_gpus_free = s_gf;
    res.local_spawns = local_count;
    res.remote_spawns = remote_count;
    res.failed_spawns = failed_count;
    res.dropped_mask = dropped;
  end
endmodule
`default_nettype wire

@@ rtl/core/peer_registry_least_loaded_router.sv @@
// peer registry with least-loaded spawn routing: top level
// each item runs an entry-serial match scan, an action step, a sweep scan on a sweep tick,
//   a summary scan and output; a new item is accepted only once the result has been published
//   to the output register; a sweep_interval write holds off input while the remainder is rebuilt
// reset (rst, synchronous): table offline, names and ticks zero, counters zero,
//   timeout_ticks 30, sweep_interval 10
`default_nettype none
`include "peer_registry_least_loaded_router_macros.svh"
module peer_registry_least_loaded_router import prr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);
  dp_cmd_t   cmd;
  dp_stat_t  st;
  out_item_t res;
  logic      in_ready;
  logic      in_fire;
  logic      out_busy;

  // item accepted from upstream
  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;
  // output register still holds an item not yet taken
  assign out_busy = out_valid && out_stall;

  prr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .st(st), .in_ready(in_ready), .cmd(cmd)
  );

  prr_dp u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .st(st), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.publish) out_data <= res;
  end

  `PRR_ASSERT_IMP(a_publish_free, cmd.publish, !out_busy)
  `PRR_ASSERT_NEXT(a_accept_busy, in_fire, in_stall)
  `PRR_ASSERT_IMP(a_status_range, out_valid, out_data.status <= ST_NOPEER)
endmodule
`default_nettype wire
